// ===== design/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, constants and the word mixing function of the cipher chain.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_0 = 2'd0;
    localparam logic [1:0] CFG_KEY_1 = 2'd1;
    localparam logic [1:0] CFG_KEY_2 = 2'd2;
    localparam logic [1:0] CFG_KEY_3 = 2'd3;

    // Operation codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [3:0][31:0] t_key;

    // Control carried alongside each block through the chain
    typedef struct packed {
        logic vld;
        logic cmd;
        logic last;
    } t_ctl;

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

// ===== design/xtea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// XTEA block cipher
// Pipelined 64-bit XTEA encrypt/decrypt under a 128-bit configured key.
// ----------------------------------------------------------------------------
// The block is a row of 2*CYCLE_COUNT cells, each doing one half of an XTEA
// cycle and registering the result, so it accepts one block per clock while
// the row advances and passes it on from cell register to cell register.
// The last cell is the output register; the whole row advances whenever that
// register is empty or its transfer completes, so a stalled output holds the
// row. Encrypt and decrypt blocks may be mixed freely. Write the key words
// only while no block is in flight.
module xtea_block_cipher
    import xtea_pkg::*;
#(
    parameter int CYCLE_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_block_high,
    input  logic [31:0] i_block_low,
    input  logic        i_last_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_high,
    output logic [31:0] o_result_low,
    output logic        o_result_last
);

    localparam int STEPS = 2 * CYCLE_COUNT;

    t_key        r_key;
    t_ctl        ctl [STEPS+1];
    logic [31:0] hi  [STEPS+1];
    logic [31:0] lo  [STEPS+1];
    logic        adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_0: r_key[0] <= i_cfg_data;
                CFG_KEY_1: r_key[1] <= i_cfg_data;
                CFG_KEY_2: r_key[2] <= i_cfg_data;
                CFG_KEY_3: r_key[3] <= i_cfg_data;
                default:   r_key    <= r_key;
            endcase
        end
    end

    // advance the row when the output register is free or being taken
    assign adv = !ctl[STEPS].vld || i_ready;

    assign ctl[0] = '{vld: i_valid, cmd: i_command, last: i_last_block};
    assign hi[0]  = i_block_high;
    assign lo[0]  = i_block_low;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        xtea_cell #(
            .STEP        (g),
            .CYCLE_COUNT (CYCLE_COUNT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_key   (r_key),
            .i_ctl   (ctl[g]),
            .i_hi    (hi[g]),
            .i_lo    (lo[g]),
            .o_ctl   (ctl[g+1]),
            .o_hi    (hi[g+1]),
            .o_lo    (lo[g+1])
        );
    end

    assign o_ready       = adv;
    assign o_valid       = ctl[STEPS].vld;
    assign o_result_high = hi[STEPS];
    assign o_result_low  = lo[STEPS];
    assign o_result_last = ctl[STEPS].last;

endmodule

// ===== design/xtea_cell.sv =====
// ----------------------------------------------------------------------------
// XTEA cell
// One half-cycle of XTEA: updates one word of the block from the other and
// registers the pair. Round constants follow from the cell's place in the row.
// ----------------------------------------------------------------------------
module xtea_cell
    import xtea_pkg::*;
#(
    parameter int STEP        = 0,
    parameter int CYCLE_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_key        i_key,
    input  t_ctl        i_ctl,
    input  logic [31:0] i_hi,
    input  logic [31:0] i_lo,
    output t_ctl        o_ctl,
    output logic [31:0] o_hi,
    output logic [31:0] o_lo
);

    localparam int   HALF  = STEP / 2;
    localparam logic EVEN  = ((STEP % 2) == 0);
    localparam int   ENC_K = EVEN ? HALF : HALF + 1;
    localparam int   DEC_K = EVEN ? CYCLE_COUNT - HALF : CYCLE_COUNT - 1 - HALF;

    localparam logic [31:0] ENC_SUM = 32'(64'(XTEA_DELTA) * 64'(ENC_K));
    localparam logic [31:0] DEC_SUM = 32'(64'(XTEA_DELTA) * 64'(DEC_K));
    localparam logic [1:0]  ENC_IDX = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
    localparam logic [1:0]  DEC_IDX = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

    t_ctl        r_ctl;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    t_ctl        n_ctl;
    logic [31:0] n_hi;
    logic [31:0] n_lo;

    logic        dec;
    logic        upd_hi;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] ks;
    logic [31:0] tweak;
    logic [31:0] upd;

    always_comb begin
        dec    = (i_ctl.cmd == CMD_DECRYPT);
        // encrypt even and decrypt odd steps update the high word
        upd_hi = (EVEN != dec);
        src    = upd_hi ? i_lo : i_hi;
        tgt    = upd_hi ? i_hi : i_lo;
        ks     = dec ? (DEC_SUM + i_key[DEC_IDX]) : (ENC_SUM + i_key[ENC_IDX]);
        tweak  = mix_word(src) ^ ks;
        upd    = dec ? (tgt - tweak) : (tgt + tweak);
        n_ctl  = i_ctl;
        n_hi   = upd_hi ? upd : i_hi;
        n_lo   = upd_hi ? i_lo : upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_hi  = r_hi;
    assign o_lo  = r_lo;

endmodule

// ===== design/xtea_checker.sv =====
// ----------------------------------------------------------------------------
// XTEA checker
// Port-level assertions on the cipher's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module xtea_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_res_high,
    input logic [31:0] i_res_low,
    input logic        i_res_last
);

    // a result never shows right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // input side is held exactly when a result waits untaken
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_res_high) && $stable(i_res_low)
            && $stable(i_res_last))
        else $error("stalled result changed");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_res_high  (o_result_high),
    .i_res_low   (o_result_low),
    .i_res_last  (o_result_last)
);

// ===== sim/xtea_block_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Streams encrypt and decrypt blocks through the cipher pipeline under several
// keys. Expected words are computed here from the configured key and checked
// in order against the output stream, with random stalls on both sides.
// ----------------------------------------------------------------------------
module xtea_block_cipher_tb;
    import xtea_pkg::*;

    localparam int ROUNDS  = 32;
    localparam int LATENCY = 2 * ROUNDS;

    typedef struct {
        logic        cmd;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        last;
    } t_block;

    typedef struct {
        logic [31:0] hi;
        logic [31:0] lo;
        logic        last;
    } t_cipher_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_index  = CFG_KEY_0;
    logic [31:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic        i_command    = CMD_ENCRYPT;
    logic [31:0] i_block_high = '0;
    logic [31:0] i_block_low  = '0;
    logic        i_last_block = 1'b0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_result_high;
    logic [31:0] o_result_low;
    logic        o_result_last;

    logic [31:0]  key_copy [4];
    t_block       block_queue [$];
    t_cipher_word cipher_queue [$];
    t_block       next_block;
    t_cipher_word oldest;
    logic         in_xfer     = 1'b0;
    int           tx_idle_pct = 24;
    int           rx_idle_pct = 74;
    int           error_count = 0;

    xtea_block_cipher #(
        .CYCLE_COUNT(ROUNDS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_block_high (i_block_high),
        .i_block_low  (i_block_low),
        .i_last_block (i_last_block),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_high(o_result_high),
        .o_result_low (o_result_low),
        .o_result_last(o_result_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] fold_word(input logic [31:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    // Full XTEA transform of one block under the current key copy
    function automatic logic [63:0] xtea_transform(input logic cmd, input logic [31:0] hi,
                                                   input logic [31:0] lo);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
        a = hi;
        b = lo;
        if (cmd == CMD_ENCRYPT) begin
            sum = '0;
            for (int n = 0; n < ROUNDS; n++) begin
                a   = a + (fold_word(b) ^ (sum + key_copy[sum[1:0]]));
                sum = sum + XTEA_DELTA;
                b   = b + (fold_word(a) ^ (sum + key_copy[sum[12:11]]));
            end
        end else begin
            sum = XTEA_DELTA * ROUNDS;
            for (int n = 0; n < ROUNDS; n++) begin
                b   = b - (fold_word(a) ^ (sum + key_copy[sum[12:11]]));
                sum = sum - XTEA_DELTA;
                a   = a - (fold_word(b) ^ (sum + key_copy[sum[1:0]]));
            end
        end
        return {a, b};
    endfunction

    function automatic t_block make_block(input logic cmd, input logic [31:0] hi,
                                          input logic [31:0] lo, input logic last);
        t_block blk;
        blk.cmd  = cmd;
        blk.hi   = hi;
        blk.lo   = lo;
        blk.last = last;
        return blk;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000 >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_random(input int count);
        logic [63:0] enc;
        t_block      blk;
        int          n;
        n = 0;
        while (n < count) begin
            blk = make_block(1'($urandom_range(0, 1)), random_word(), random_word(),
                             1'($urandom_range(0, 1)));
            block_queue.push_back(blk);
            n++;
            // Now and then chase an encryption with the decryption of its result
            if (blk.cmd == CMD_ENCRYPT && $urandom_range(0, 3) == 0 && n < count) begin
                enc = xtea_transform(CMD_ENCRYPT, blk.hi, blk.lo);
                block_queue.push_back(make_block(CMD_DECRYPT, enc[63:32], enc[31:0],
                                                 ~blk.last));
                n++;
            end
        end
    endtask

    task automatic write_key(input logic [1:0] index, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        key_copy[index] = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        write_key(CFG_KEY_0, k0);
        write_key(CFG_KEY_1, k1);
        write_key(CFG_KEY_2, k2);
        write_key(CFG_KEY_3, k3);
    endtask

    // Hold until every queued block has gone in and every result has come out
    task automatic drain();
        do
            @(negedge i_clk);
        while (block_queue.size() != 0 || i_valid || cipher_queue.size() != 0);
    endtask

    // Sender: hold the payload until transfer, then take the next block or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_xfer) begin
            if (block_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                next_block = block_queue.pop_front();
                i_valid      <= 1'b1;
                i_command    <= next_block.cmd;
                i_block_high <= next_block.hi;
                i_block_low  <= next_block.lo;
                i_last_block <= next_block.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Record input transfers as expectations, then check output transfers
    always @(posedge i_clk) begin
        logic [63:0]  words;
        t_cipher_word exp_word;
        if (!i_rst_n) begin
            in_xfer <= 1'b0;
        end else begin
            in_xfer <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                words = xtea_transform(i_command, i_block_high, i_block_low);
                exp_word.hi   = words[63:32];
                exp_word.lo   = words[31:0];
                exp_word.last = i_last_block;
                cipher_queue.push_back(exp_word);
            end
            if (o_valid && i_ready) begin
                if (cipher_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: high %h low %h last %b",
                                 o_result_high, o_result_low, o_result_last);
                end else begin
                    oldest = cipher_queue.pop_front();
                    if (o_result_high !== oldest.hi || o_result_low !== oldest.lo ||
                        o_result_last !== oldest.last) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected %h %h %b, got %h %h %b",
                                     oldest.hi, oldest.lo, oldest.last,
                                     o_result_high, o_result_low, o_result_last);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("xtea_block_cipher test failed");
        $finish;
    end

    initial begin
        logic [63:0] enc;
        logic [31:0] pt_hi;
        logic [31:0] pt_lo;
        for (int k = 0; k < 4; k++)
            key_copy[k] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed blocks under the all-zero reset key
        block_queue.push_back(make_block(CMD_ENCRYPT, 32'h0, 32'h0, 1'b0));
        block_queue.push_back(make_block(CMD_DECRYPT, 32'h0, 32'h0, 1'b1));
        block_queue.push_back(make_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        block_queue.push_back(make_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        drain();

        // Directed blocks under the all-ones key, including round trips
        load_key('1, '1, '1, '1);
        block_queue.push_back(make_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0));
        block_queue.push_back(make_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1));
        block_queue.push_back(make_block(CMD_ENCRYPT, 32'h0, 32'hFFFF_FFFF, 1'b1));
        block_queue.push_back(make_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0, 1'b0));
        for (int n = 0; n < 6; n++) begin
            pt_hi = $urandom();
            pt_lo = $urandom();
            enc   = xtea_transform(CMD_ENCRYPT, pt_hi, pt_lo);
            block_queue.push_back(make_block(CMD_ENCRYPT, pt_hi, pt_lo, n[0]));
            block_queue.push_back(make_block(CMD_DECRYPT, enc[63:32], enc[31:0], ~n[0]));
        end
        drain();

        // Random traffic, sender lightly idle and receiver mostly stalled
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        queue_random(85);
        drain();
        queue_random(85);
        drain();

        tx_idle_pct = 74;
        rx_idle_pct = 24;
        load_key(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_random(170);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        queue_random(160);
        drain();

        repeat (LATENCY + 16) @(negedge i_clk);
        if (error_count == 0 && cipher_queue.size() == 0)
            $display("xtea_block_cipher test passed");
        else
            $display("xtea_block_cipher test failed");
        $finish;
    end

endmodule

// ===== xtea_block_cipher.f =====
design/xtea_pkg.sv
design/xtea_cell.sv
design/xtea_block_cipher.sv
design/xtea_checker.sv
sim/xtea_block_cipher_tb.sv
